// ===== rtl/tsbe_pkg.sv =====
// Shared types, constants and tables for the two-spin basis enumerator.
// Used by the register block, the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package tsbe_pkg;

	// Field widths of the configuration registers and of the payload.
	localparam int CNT_W   = 5;
	localparam int WORD_W  = 32;
	localparam int MOM_W   = 4;
	localparam int IN_W    = 8;
	localparam int TDATA_W = 40;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	// Index sums reach at most 240 for two halves of sixteen sites.
	localparam int SUM_W     = 8;
	// Reciprocal arithmetic for the momentum remainder.
	localparam int REC_W     = 13;
	localparam int REC_SHIFT = 12;
	localparam int PROD_W    = SUM_W + REC_W;
	localparam int Q_W       = PROD_W - REC_SHIFT;
	localparam int QN_W      = Q_W + CNT_W;

	// Register reset values.
	localparam logic [CNT_W-1:0] RST_NUM_SITES  = CNT_W'(4);
	localparam logic [CNT_W-1:0] RST_COUNT_UP   = CNT_W'(2);
	localparam logic [CNT_W-1:0] RST_COUNT_DOWN = CNT_W'(2);

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_NUM_SITES  = 2'd0,
		REG_COUNT_UP   = 2'd1,
		REG_COUNT_DOWN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] num_sites;
		logic [CNT_W-1:0] count_up;
		logic [CNT_W-1:0] count_down;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PACK,
		ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic eval;
		logic pack;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// floor(4096 / n) for n from 1 to 16; codes outside that range mean nothing.
	function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [REC_W-1:0] r;
		case (n)
			5'd1:    r = REC_W'(4096);
			5'd2:    r = REC_W'(2048);
			5'd3:    r = REC_W'(1365);
			5'd4:    r = REC_W'(1024);
			5'd5:    r = REC_W'(819);
			5'd6:    r = REC_W'(682);
			5'd7:    r = REC_W'(585);
			5'd8:    r = REC_W'(512);
			5'd9:    r = REC_W'(455);
			5'd10:   r = REC_W'(409);
			5'd11:   r = REC_W'(372);
			5'd12:   r = REC_W'(341);
			5'd13:   r = REC_W'(315);
			5'd14:   r = REC_W'(292);
			5'd15:   r = REC_W'(273);
			5'd16:   r = REC_W'(256);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/tsbe_regs.sv =====
// APB-style configuration registers: site count and the two particle counts.
// Flags every write to a known register so the datapath can end the run.
// Depends on tsbe_pkg.
`timescale 1ns / 1ps

module tsbe_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsbe_pkg::APB_AW-1:0]  paddr,
	input  logic [tsbe_pkg::APB_DW-1:0]  pwdata,
	output logic [tsbe_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output tsbe_pkg::cfg_t               cfg,
	output logic                         cfg_wr
);
	import tsbe_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic     hit;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign cfg_wr = wr_en & hit;

	// Address decode: the fourth slot holds no register.
	always_comb begin
		unique case (idx)
			REG_NUM_SITES:  hit = 1'b1;
			REG_COUNT_UP:   hit = 1'b1;
			REG_COUNT_DOWN: hit = 1'b1;
			default:        hit = 1'b0;
		endcase
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_sites  <= RST_NUM_SITES;
			cfg_q.count_up   <= RST_COUNT_UP;
			cfg_q.count_down <= RST_COUNT_DOWN;
		end else if (wr_en) begin
			unique case (idx)
				REG_NUM_SITES:  cfg_q.num_sites  <= pwdata[CNT_W-1:0];
				REG_COUNT_UP:   cfg_q.count_up   <= pwdata[CNT_W-1:0];
				REG_COUNT_DOWN: cfg_q.count_down <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back.
	always_comb begin
		unique case (idx)
			REG_NUM_SITES:  prdata = APB_DW'(cfg_q.num_sites);
			REG_COUNT_UP:   prdata = APB_DW'(cfg_q.count_up);
			REG_COUNT_DOWN: prdata = APB_DW'(cfg_q.count_down);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/tsbe_ctrl.sv =====
// Controller state machine: sequences one item through load, evaluate, pack
// and output. Depends on tsbe_pkg.
`timescale 1ns / 1ps

module tsbe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tsbe_pkg::dp_stat_t  stat,
	output tsbe_pkg::dp_cmd_t   cmd
);
	import tsbe_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: state_d = ST_PACK;
			ST_PACK: state_d = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EVAL: cmd.eval = 1'b1;
			ST_PACK: cmd.pack = 1'b1;
			ST_OUT:  cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tsbe_dp.sv =====
// Datapath: spin patterns, next-pattern search and repack, index sums,
// momentum remainder and the output register. Depends on tsbe_pkg.
`timescale 1ns / 1ps

module tsbe_dp #(
	parameter int MAX_SITES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsbe_pkg::cfg_t                cfg,
	input  logic                          cfg_wr,
	input  logic                          restart,
	input  tsbe_pkg::dp_cmd_t             cmd,
	output tsbe_pkg::dp_stat_t            stat,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [tsbe_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] occupation_word, [35:32] momentum
	output logic                          m_tlast,   // is_last
	output logic                          m_tuser    // valid_res
);
	import tsbe_pkg::*;

	localparam int PW   = MAX_SITES;
	localparam int NG   = (PW + 3) / 4;
	localparam int PADW = NG * 4;
	localparam int PADO = TDATA_W - WORD_W - MOM_W;

	// Result of the search for the element that moves next.
	typedef struct packed {
		logic             has;
		logic [PW-1:0]    keep;
		logic [CNT_W-1:0] apos;
		logic [CNT_W-1:0] len;
	} find_t;

	// Fill every bit below the highest set bit.
	function automatic logic [PW-1:0] smear_down(input logic [PW-1:0] x);
		logic [PW-1:0] s;
		s = x;
		for (int k = 1; k < PW; k = k * 2) s = s | (s >> k);
		return s;
	endfunction

	// Position of the single set bit of a one-hot word.
	function automatic logic [CNT_W-1:0] pos_of(input logic [PW-1:0] oh);
		logic [CNT_W-1:0] p;
		p = '0;
		for (int b = 0; b < PW; b++) if (oh[b]) p = p | CNT_W'(b);
		return p;
	endfunction

	// The lowest k bits set.
	function automatic logic [PW-1:0] low_ones(input logic [CNT_W-1:0] k);
		logic [PW:0] w;
		w = ({{PW{1'b0}}, 1'b1} << k) - 1'b1;
		return w[PW-1:0];
	endfunction

	// Sum of the indices of set bits, in groups of four.
	function automatic logic [SUM_W-1:0] idx_sum(input logic [PW-1:0] p);
		logic [PADW-1:0]  pp;
		logic [SUM_W-1:0] pt;
		logic [SUM_W-1:0] s;
		pp = PADW'(p);
		s  = '0;
		for (int g = 0; g < NG; g++) begin
			pt = '0;
			for (int j = 0; j < 4; j++) if (pp[g*4+j]) pt = pt + SUM_W'(g * 4 + j);
			s = s + pt;
		end
		return s;
	endfunction

	// Highest zero below n marks the top block; the highest one beneath it moves.
	function automatic find_t find_next(input logic [PW-1:0] p, input logic [CNT_W-1:0] n);
		logic [PW-1:0] z;
		logic [PW-1:0] sz;
		logic [PW-1:0] cand;
		logic [PW-1:0] sa;
		find_t         f;
		z      = ~p & low_ones(n);
		sz     = smear_down(z);
		cand   = p & (sz >> 1);
		sa     = smear_down(cand);
		f.has  = |cand;
		f.keep = p & (sa >> 1);
		f.apos = pos_of(sa & ~(sa >> 1));
		f.len  = n - pos_of(sz & ~(sz >> 1));
		return f;
	endfunction

	// Rebuild: kept low part plus a block of ones just above the moved element.
	function automatic logic [PW-1:0] repack(input find_t f);
		logic [CNT_W-1:0] sh;
		sh = f.apos + 1'b1;
		return f.keep | (low_ones(f.len) << sh);
	endfunction

	// Pattern state.
	logic [PW-1:0] up_q, down_q;
	logic          fin_q;
	logic [PW-1:0] up_d, down_d;
	logic          fin_d, v_d;
	logic          bad;

	// Successors prepared after the previous item.
	logic [PW-1:0] next_up_q, next_down_q;
	logic          has_up_q, has_down_q;

	// Pipeline registers.
	logic              v_s1;
	find_t             fu_s2, fd_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              v_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic              last_s3, v_s3;

	// Output stage.
	logic [Q_W-1:0]    quo;
	logic [QN_W-1:0]   qn, diff;
	logic [CNT_W-1:0]  r0, rem;
	logic [WORD_W-1:0] word;
	logic              full_q;
	logic [TDATA_W-1:0] tdata_q;
	logic              tlast_q, tuser_q;

	assign bad = (cfg.num_sites == '0) || (cfg.num_sites > CNT_W'(MAX_SITES)) ||
		(cfg.count_up > cfg.num_sites) || (cfg.count_down > cfg.num_sites);

	// New pattern state for an accepted item.
	always_comb begin
		up_d   = up_q;
		down_d = down_q;
		fin_d  = fin_q;
		v_d    = 1'b0;
		if (restart) begin
			if (bad) begin
				fin_d = 1'b1;
			end else begin
				up_d   = low_ones(cfg.count_up);
				down_d = low_ones(cfg.count_down);
				fin_d  = 1'b0;
				v_d    = 1'b1;
			end
		end else if (!fin_q) begin
			if (has_down_q) begin
				down_d = next_down_q;
				v_d    = 1'b1;
			end else if (has_up_q) begin
				up_d   = next_up_q;
				down_d = low_ones(cfg.count_down);
				v_d    = 1'b1;
			end else begin
				fin_d = 1'b1;
			end
		end
	end

	// Pattern registers; a register write ends the current run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= '0;
			down_q <= '0;
			fin_q  <= 1'b1;
		end else if (cmd.load) begin
			up_q   <= up_d;
			down_q <= down_d;
			fin_q  <= fin_d;
		end else if (cfg_wr) begin
			fin_q <= 1'b1;
		end
	end

	// Evaluate, pack and multiply stages.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_s1 <= v_d;
		end
		if (cmd.eval) begin
			fu_s2  <= find_next(up_q, cfg.num_sites);
			fd_s2  <= find_next(down_q, cfg.num_sites);
			sum_s2 <= idx_sum(up_q) + idx_sum(down_q);
			v_s2   <= v_s1;
		end
		if (cmd.pack) begin
			next_up_q   <= repack(fu_s2);
			next_down_q <= repack(fd_s2);
			has_up_q    <= fu_s2.has;
			has_down_q  <= fd_s2.has;
			prod_s3     <= PROD_W'(sum_s2) * PROD_W'(recip(cfg.num_sites));
			sum_s3      <= sum_s2;
			last_s3     <= !fu_s2.has && !fd_s2.has;
			v_s3        <= v_s2;
		end
	end

	// Remainder: the reciprocal quotient is exact or one short.
	always_comb begin
		quo  = prod_s3[PROD_W-1:REC_SHIFT];
		qn   = QN_W'(quo) * QN_W'(cfg.num_sites);
		diff = QN_W'(sum_s3) - qn;
		r0   = diff[CNT_W-1:0];
		rem  = (r0 >= cfg.num_sites) ? r0 - cfg.num_sites : r0;
		word = (WORD_W'(down_q) << cfg.num_sites) | WORD_W'(up_q);
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tdata_q <= v_s3 ? {{PADO{1'b0}}, rem[MOM_W-1:0], word} : '0;
			tlast_q <= v_s3 & last_s3;
			tuser_q <= v_s3;
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.out_load) begin
			full_q <= 1'b1;
		end else if (m_tready) begin
			full_q <= 1'b0;
		end
	end

	assign stat.out_free = !full_q || m_tready;
	assign m_tvalid      = full_q;
	assign m_tdata       = tdata_q;
	assign m_tlast       = tlast_q;
	assign m_tuser       = tuser_q;

endmodule

// ===== rtl/two_spin_combination_basis_enumerator_top.sv =====
// Top level of the two-spin basis enumerator: registers, controller, datapath.
// Depends on tsbe_pkg, tsbe_regs, tsbe_ctrl and tsbe_dp.
//
// Use: set num_sites, count_up and count_down over the APB port (byte
// addresses 0, 4, 8) while no item is in flight. Send an item with restart
// set to get the first occupation word, then items with restart clear to
// step through the basis, the down half fastest. Each result carries the
// word and its momentum in m_tdata, the final-word flag in m_tlast and a
// valid flag in m_tuser; invalid results have all other fields zero.
// A result is shown from the output register. The controller walks each
// item through the pattern load, search, repack with the reciprocal multiply,
// and remainder with output load before it takes the next one; the next item
// is taken while the previous result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// block stops after one further item until it is taken.
// Reset clears the registers to 4, 2, 2 and leaves no run open: an item
// without restart then gives an invalid result. Any write to one of the three registers does too.
`timescale 1ns / 1ps

module two_spin_combination_basis_enumerator_top #(
	parameter int MAX_SITES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tsbe_pkg::IN_W-1:0]     s_tdata,   // [0] restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsbe_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] occupation_word, [35:32] momentum
	output logic                          m_tlast,   // is_last
	output logic                          m_tuser,   // valid_res
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsbe_pkg::APB_AW-1:0]   paddr,
	input  logic [tsbe_pkg::APB_DW-1:0]   pwdata,
	output logic [tsbe_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import tsbe_pkg::*;

	cfg_t     cfg;
	logic     cfg_wr;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	tsbe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	tsbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsbe_dp #(
		.MAX_SITES (MAX_SITES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_wr   (cfg_wr),
		.restart  (s_tdata[0]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// A result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten while stalled");

	// An accepted item keeps the input closed for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in flight");

	// An invalid result carries no word, momentum or final flag.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> ((m_tdata == '0) && !m_tlast))
		else $error("invalid result with non-zero payload");

	// Momentum is a remainder modulo the site count.
	a_mom_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(CNT_W'(m_tdata[WORD_W +: MOM_W]) < cfg.num_sites))
		else $error("momentum not below site count");

endmodule
